FILE: hdl/sha256bs_pkg.sv
// Shared types, constants and helper functions for the SHA-256 byte-stream hasher.
`timescale 1ns / 1ps

package sha256bs_pkg;

  // Eight 32-bit words, index 0 is word a (or H0).
  typedef logic [7:0][31:0] word8_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_UPDATE,
    ST_PAD,
    ST_OUT
  } state_e;

  localparam int unsigned Rounds     = 64;
  localparam logic [5:0]  LenPos     = 6'd56;
  localparam logic [5:0]  LastByte   = 6'd63;
  localparam logic [5:0]  LastRound  = 6'd63;
  localparam logic [7:0]  PadByte    = 8'h80;
  localparam logic [2:0]  LastIdx    = 3'd7;

  localparam word8_t InitHash = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [31:0] RoundK [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    big_sig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    big_sig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    small_sig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    small_sig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

FILE: hdl/sha256bs_round.sv
// One SHA-256 round and the matching message schedule step.
`timescale 1ns / 1ps

module sha256bs_round import sha256bs_pkg::*; (
  input  word8_t        v_i,
  input  logic [511:0]  win_i,
  input  logic [31:0]   k_i,
  output word8_t        v_o,
  output logic [31:0]   w_new_o
);

  logic [31:0] w_cur;
  logic [31:0] ch;
  logic [31:0] maj;
  logic [31:0] t1;
  logic [31:0] t2;

  // Window holds W[t] in the top word, W[t+15] in the bottom word.
  assign w_cur = win_i[511:480];

  assign ch  = (v_i[4] & v_i[5]) ^ (~v_i[4] & v_i[6]);
  assign maj = (v_i[0] & v_i[1]) ^ (v_i[0] & v_i[2]) ^ (v_i[1] & v_i[2]);
  assign t1  = v_i[7] + big_sig1(v_i[4]) + ch + k_i + w_cur;
  assign t2  = big_sig0(v_i[0]) + maj;

  assign v_o[0] = t1 + t2;
  assign v_o[1] = v_i[0];
  assign v_o[2] = v_i[1];
  assign v_o[3] = v_i[2];
  assign v_o[4] = v_i[3] + t1;
  assign v_o[5] = v_i[4];
  assign v_o[6] = v_i[5];
  assign v_o[7] = v_i[6];

  // W[t+16] from W[t+14], W[t+9], W[t+1] and W[t].
  assign w_new_o = small_sig1(win_i[63:32]) + win_i[223:192]
                 + small_sig0(win_i[479:448]) + w_cur;

endmodule

FILE: hdl/sha256_byte_stream_hasher.sv
// Top level of the SHA-256 byte-stream hasher: byte intake, padding, rounds, digest output.
`timescale 1ns / 1ps
//
// Input channel: one word per accepted item carries msg_byte_i (used when
// byte_valid_i is high) and msg_end_i. An item is taken when in_valid_i is high
// and in_stall_o is low. Bytes are taken one per cycle while a block fills.
// The 64th byte of a block starts a compression: 64 rounds at one round per
// cycle on a single shared round unit, then a fold of the result into the
// chaining state; in_stall_o is high while the block is compressed.
// At the end mark the sequencer inserts 0x80, zero bytes and the 64-bit length
// one byte a cycle, with one or two more compressions.
// The digest then goes out as eight words on the output channel, word 0
// first, last_word_o on word 7. out_valid_o stays high and the word holds while
// out_stall_i is high. After word 7 is taken the block returns to the initial
// hash values and accepts the next message.
// Reset clears the chaining state to the initial values and all counters.

module sha256_byte_stream_hasher import sha256bs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  msg_byte_i,
  input  logic        byte_valid_i,
  input  logic        msg_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  state_e       state_q, state_d;
  logic [511:0] win_q;
  word8_t       v_q;
  word8_t       hash_q;
  logic [5:0]   fill_q;
  logic [5:0]   round_q;
  logic [60:0]  cnt_q;
  logic [2:0]   oidx_q;
  logic         end_q;
  logic         sent80_q;
  logic         lenok_q;
  logic         final_q;

  word8_t       v_next;
  logic [31:0]  w_new;
  logic         in_acc;
  logic         out_acc;
  logic         byte_shift;
  logic [7:0]   byte_in;
  logic         len_mode;
  logic         wrap;
  logic [63:0]  len_sh;

  sha256bs_round u_round (
    .v_i     (v_q),
    .win_i   (win_q),
    .k_i     (RoundK[round_q]),
    .v_o     (v_next),
    .w_new_o (w_new)
  );

  assign in_acc   = in_valid_i & ~in_stall_o;
  assign out_acc  = out_valid_o & ~out_stall_i;
  assign len_mode = sent80_q & lenok_q & (fill_q >= LenPos);
  assign len_sh   = {cnt_q, 3'b000} << {fill_q[2:0], 3'b000};
  assign wrap     = byte_shift & (fill_q == LastByte);

  // Output decode.
  always_comb begin
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    byte_shift  = 1'b0;
    byte_in     = msg_byte_i;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        byte_shift = in_valid_i & byte_valid_i;
      end
      ST_PAD: begin
        byte_shift = 1'b1;
        if (!sent80_q) begin
          byte_in = PadByte;
        end else if (len_mode) begin
          byte_in = len_sh[63:56];
        end else begin
          byte_in = 8'h00;
        end
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (wrap) begin
            state_d = ST_ROUND;
          end else if (msg_end_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        if (round_q == LastRound) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (final_q) begin
          state_d = ST_OUT;
        end else if (end_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_PAD: begin
        if (wrap) begin
          state_d = ST_ROUND;
        end
      end
      ST_OUT: begin
        if (out_acc && oidx_q == LastIdx) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      hash_q   <= InitHash;
      fill_q   <= '0;
      round_q  <= '0;
      cnt_q    <= '0;
      oidx_q   <= '0;
      end_q    <= 1'b0;
      sent80_q <= 1'b0;
      lenok_q  <= 1'b0;
      final_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (state_q == ST_IDLE && in_acc) begin
        end_q <= msg_end_i;
        if (byte_valid_i) begin
          cnt_q <= cnt_q + 61'd1;
        end
      end

      if (byte_shift) begin
        fill_q <= fill_q + 6'd1;
      end

      if (state_q == ST_PAD) begin
        if (!sent80_q) begin
          sent80_q <= 1'b1;
        end else if (len_mode) begin
          final_q <= 1'b1;
        end
        if (wrap) begin
          lenok_q <= 1'b1;
        end else if (!sent80_q) begin
          // Length fits behind the pad byte only if it lands before byte 56.
          lenok_q <= (fill_q < LenPos);
        end
      end

      if (wrap) begin
        round_q <= '0;
      end else if (state_q == ST_ROUND) begin
        round_q <= round_q + 6'd1;
      end

      if (state_q == ST_UPDATE) begin
        for (int i = 0; i < 8; i++) begin
          hash_q[i] <= hash_q[i] + v_q[i];
        end
      end

      if (out_acc) begin
        oidx_q <= oidx_q + 3'd1;
        if (oidx_q == LastIdx) begin
          // Back to the initial values for the next message.
          hash_q   <= InitHash;
          fill_q   <= '0;
          cnt_q    <= '0;
          end_q    <= 1'b0;
          sent80_q <= 1'b0;
          lenok_q  <= 1'b0;
          final_q  <= 1'b0;
        end
      end
    end
  end

  // Message window and working variables.
  always_ff @(posedge clk_i) begin
    if (byte_shift) begin
      win_q <= {win_q[503:0], byte_in};
    end else if (state_q == ST_ROUND) begin
      win_q <= {win_q[479:0], w_new};
    end
    if (wrap) begin
      v_q <= hash_q;
    end else if (state_q == ST_ROUND) begin
      v_q <= v_next;
    end
  end

  assign digest_word_o = hash_q[oidx_q];
  assign word_index_o  = oidx_q;
  assign last_word_o   = (oidx_q == LastIdx);

endmodule

FILE: tb/testbench.sv
// Self-checking bench for the SHA-256 byte-stream hasher: byte messages in, digest words checked.
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       ends;
  } hash_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  localparam logic [31:0] RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] StartHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Message lengths around the block and padding boundaries
  localparam int unsigned EdgeLens [6] = '{0, 55, 56, 63, 64, 65};

  localparam int unsigned MaxGap      = 18;
  localparam int unsigned LongHold    = 1500;
  localparam int unsigned DrainCycles = 300;
  localparam int unsigned RandBytes   = 220;

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [7:0]  msg_byte   = '0;
  logic        byte_valid = 1'b0;
  logic        msg_end    = 1'b0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  // Predictor state
  logic [7:0]   msg_block [64];
  int unsigned  block_bytes;
  logic [63:0]  msg_bits;
  logic [31:0]  chain [8];

  hash_item_t   pending_items [$];
  digest_word_t expected_digest [$];
  hash_item_t   shown_item;

  int unsigned  send_wait = 0;
  int unsigned  recv_wait = 0;
  bit           send_calm = 1'b0;
  bit           recv_calm = 1'b0;
  int unsigned  items_taken = 0;
  int unsigned  total_items = 0;
  int unsigned  directed_count = 0;
  int unsigned  hold_left = 0;
  bit           hold_armed = 1'b0;

  int unsigned  n_msgs = 0;
  int unsigned  n_bytes = 0;
  int unsigned  n_empty = 0;
  int unsigned  words_seen = 0;
  int unsigned  errors = 0;

  sha256_byte_stream_hasher uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .msg_byte_i    (msg_byte),
    .byte_valid_i  (byte_valid),
    .msg_end_i     (msg_end),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .digest_word_o (digest_word),
    .word_index_o  (word_index),
    .last_word_o   (last_word)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    for (int t = 0; t < 16; t++)
      w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
    for (int t = 16; t < 64; t++) begin
      s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = s1 + w[t-7] + s0 + w[t-16];
    end
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int t = 0; t < 64; t++) begin
      s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
      t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[t] + w[t];
      s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
      t2 = s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int i = 7; i > 0; i--) v[i] = v[i-1];
      // v[4] now holds the old d
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
  endfunction

  function automatic void restart_hash();
    block_bytes = 0;
    msg_bits = '0;
    for (int i = 0; i < 8; i++) chain[i] = StartHash[i];
  endfunction

  function automatic void absorb_item(input hash_item_t it);
    digest_word_t dw;
    if (it.has_byte) begin
      msg_block[block_bytes] = it.data;
      block_bytes++;
      if (block_bytes == 64) begin
        compress_block();
        msg_bits += 64'd512;
        block_bytes = 0;
      end
    end
    if (it.ends) begin
      msg_bits += 64'(block_bytes) * 64'd8;
      msg_block[block_bytes] = 8'h80;
      for (int i = block_bytes + 1; i < 64; i++) msg_block[i] = '0;
      // no room for the length: spill into a second block
      if (block_bytes >= 56) begin
        compress_block();
        for (int i = 0; i < 56; i++) msg_block[i] = '0;
      end
      for (int i = 0; i < 8; i++) msg_block[56+i] = msg_bits[63-8*i -: 8];
      compress_block();
      for (int i = 0; i < 8; i++) begin
        dw.word = chain[i];
        dw.idx  = 3'(i);
        dw.last = (i == 7);
        expected_digest.push_back(dw);
      end
      restart_hash();
    end
  endfunction

  function automatic void add_item(input logic [7:0] d, input logic hb, input logic e);
    hash_item_t it;
    it.data = d;
    it.has_byte = hb;
    it.ends = e;
    pending_items.push_back(it);
    if (hb) n_bytes++;
    if (e) n_msgs++;
    if (!hb && !e) n_empty++;
  endfunction

  function automatic int unsigned draw_gap(inout bit calm);
    if ($urandom_range(0, 19) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, MaxGap);
  endfunction

  // Driver: advance to the next word once the current one is taken
  always @(posedge clk_i) begin : feed
    bit taken;
    taken = in_valid && !in_stall;
    if (rst_ni) begin
      if (taken) begin
        absorb_item(shown_item);
        items_taken <= items_taken + 1;
      end
      if (!in_valid || taken) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          shown_item = pending_items.pop_front();
          msg_byte   <= shown_item.data;
          byte_valid <= shown_item.has_byte;
          msg_end    <= shown_item.ends;
          in_valid   <= 1'b1;
          send_wait  = draw_gap(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Hold the output off once, long enough for the input side to back up
  always @(posedge clk_i) begin : long_hold
    if (rst_ni) begin
      if (!hold_armed && items_taken >= directed_count) begin
        hold_left  <= LongHold;
        hold_armed <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  always @(posedge clk_i) begin : collect
    digest_word_t want;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        words_seen++;
        if (expected_digest.size() == 0) begin
          $display("%0t: unexpected digest word: expected none, got %08h idx %0d last %0b",
                   $time, digest_word, word_index, last_word);
          errors++;
        end else begin
          want = expected_digest.pop_front();
          if (digest_word !== want.word) begin
            $display("%0t: digest_word expected %08h, got %08h", $time, want.word, digest_word);
            errors++;
          end
          if (word_index !== want.idx) begin
            $display("%0t: word_index expected %0d, got %0d", $time, want.idx, word_index);
            errors++;
          end
          if (last_word !== want.last) begin
            $display("%0t: last_word expected %0b, got %0b", $time, want.last, last_word);
            errors++;
          end
        end
        recv_wait = draw_gap(recv_calm);
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int unsigned len, rand_bytes, m;
    bit tail_empty;
    restart_hash();

    // empty message
    add_item(8'($urandom), 1'b0, 1'b1);
    // "abc", end mark on the last byte
    add_item(8'h61, 1'b1, 1'b0);
    add_item(8'h62, 1'b1, 1'b0);
    add_item(8'h63, 1'b1, 1'b1);
    // skipped item, then a one-byte message of all ones
    add_item(8'($urandom), 1'b0, 1'b0);
    add_item(8'hff, 1'b1, 1'b1);
    // zero byte, skipped item, end mark on an item without a byte
    add_item(8'h00, 1'b1, 1'b0);
    add_item(8'($urandom), 1'b0, 1'b0);
    add_item(8'($urandom), 1'b0, 1'b1);
    // walking one across the byte
    for (int i = 0; i < 8; i++) add_item(8'(8'h01 << i), 1'b1, i == 7);
    add_item(8'h7f, 1'b1, 1'b0);
    add_item(8'h80, 1'b1, 1'b0);
    add_item(8'hfe, 1'b1, 1'b1);
    directed_count = pending_items.size();

    // Random messages: first two straddle the padding boundary
    rand_bytes = 0;
    m = 0;
    while (rand_bytes < RandBytes) begin
      if (m == 0) len = 55;
      else if (m == 1) len = 56;
      else if ($urandom_range(0, 3) == 0) len = EdgeLens[$urandom_range(0, 5)];
      else len = $urandom_range(0, 12);
      tail_empty = (len == 0) || ($urandom_range(0, 2) == 0);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0) add_item(8'($urandom), 1'b0, 1'b0);
        add_item(8'($urandom), 1'b1, !tail_empty && (i == len - 1));
      end
      if (tail_empty) add_item(8'($urandom), 1'b0, 1'b1);
      rand_bytes += len;
      m++;
    end
    total_items = pending_items.size();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (items_taken < total_items || expected_digest.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d messages: %0d bytes, %0d skipped items, %0d digest words checked,",
             n_msgs, n_bytes, n_empty, words_seen);
    $display("with random gaps on both sides and one output hold of %0d cycles.", LongHold);
    if (errors == 0 && expected_digest.size() == 0) begin
      $display("sha256_byte_stream_hasher: match");
    end else begin
      $display("sha256_byte_stream_hasher: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #1000000;
    $display("Timeout: %0d of %0d items taken, %0d digest words outstanding",
             items_taken, total_items, expected_digest.size());
    $display("sha256_byte_stream_hasher: mismatch");
    $finish;
  end

endmodule

FILE: sha256_byte_stream_hasher.f
hdl/sha256bs_pkg.sv
hdl/sha256bs_round.sv
hdl/sha256_byte_stream_hasher.sv
tb/testbench.sv
